[design/keypad_edge_repeat_history_top_defines.svh]
// assertion macros for the keypad edge, repeat and history block
// used by keypad_edge_repeat_history_top; expects clk_i and rst_ni in scope
`ifndef KEYPAD_EDGE_REPEAT_HISTORY_TOP_DEFINES_SVH
`define KEYPAD_EDGE_REPEAT_HISTORY_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define KERH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("kerh: assertion failed");

`define KERH_ASSERT_IMPLY(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("kerh: implication failed");

`else

`define KERH_ASSERT(lbl, prop)

`define KERH_ASSERT_IMPLY(lbl, pre, post)

`endif

`endif

[design/kerh_pkg.sv]
// shared constants, codes and interface structs for the keypad block
// used by kerh_history and keypad_edge_repeat_history_top
`timescale 1ns / 1ps

package kerh_pkg;

  // ring depth must be a power of two, index arithmetic wraps by truncation
  localparam int unsigned HISTORY_DEPTH = 16;
  localparam int unsigned KEY_WIDTH     = 16;

  localparam int unsigned HistIdxW  = $clog2(HISTORY_DEPTH);
  localparam int unsigned SeqLenW   = 5;
  localparam int unsigned SeqPosW   = 4;
  localparam int unsigned BackW     = (HistIdxW > SeqLenW) ? HistIdxW : SeqLenW;
  localparam int unsigned IntervalW = 8;
  localparam int unsigned KindW     = 2;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [SeqLenW-1:0] MaxSeqLen = 5'd16;

  localparam logic [KindW-1:0] KindFrame = 2'd0;
  localparam logic [KindW-1:0] KindSeq   = 2'd1;
  localparam logic [KindW-1:0] KindClear = 2'd2;

  localparam logic [CfgIdxW-1:0] RegRepeatInterval = 1'b0;
  localparam logic [CfgIdxW-1:0] RegRepeatMask     = 1'b1;

  typedef struct packed {
    logic                 wr_en;
    logic [KEY_WIDTH-1:0] wr_data;
    logic                 clr;
    logic                 chk_en;
    logic [KEY_WIDTH-1:0] seq_value;
    logic [SeqLenW-1:0]   seq_length;
  } hist_req_t;

  typedef struct packed {
    logic check_done;
    logic matched;
  } hist_rsp_t;

endpackage

[design/kerh_history.sv]
// pressed-key history ring and streaming sequence comparator
// depends on kerh_pkg
`timescale 1ns / 1ps

module kerh_history (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kerh_pkg::hist_req_t req_i,
  output kerh_pkg::hist_rsp_t rsp_o
);

  logic [kerh_pkg::KEY_WIDTH-1:0] ring_q [kerh_pkg::HISTORY_DEPTH];
  logic [kerh_pkg::HistIdxW-1:0]  idx_q;
  logic [kerh_pkg::SeqPosW-1:0]   pos_q;
  logic                           mis_q;

  logic [kerh_pkg::SeqLenW-1:0]  len_c;
  logic [kerh_pkg::SeqLenW-1:0]  pos_ext;
  logic [kerh_pkg::SeqLenW-1:0]  back;
  logic [kerh_pkg::BackW-1:0]    back_w;
  logic [kerh_pkg::HistIdxW-1:0] slot;
  logic [kerh_pkg::HistIdxW-1:0] idx_inc;
  logic                          elem_mis;
  logic                          mis_d;
  logic                          last;

  always_comb begin
    len_c    = (req_i.seq_length > kerh_pkg::MaxSeqLen) ? kerh_pkg::MaxSeqLen
                                                         : req_i.seq_length;
    pos_ext  = {1'b0, pos_q};
    back     = len_c - pos_ext;
    back_w   = kerh_pkg::BackW'(back);
    // entry that this element must equal, counted back from the newest
    slot     = idx_q - back_w[kerh_pkg::HistIdxW-1:0];
    elem_mis = (len_c > pos_ext) && (ring_q[slot] != req_i.seq_value);
    mis_d    = mis_q | elem_mis | (len_c >= kerh_pkg::MaxSeqLen);
    last     = (pos_ext + kerh_pkg::SeqLenW'(1)) >= len_c;
    idx_inc  = (idx_q == kerh_pkg::HistIdxW'(kerh_pkg::HISTORY_DEPTH - 1))
               ? '0 : idx_q + kerh_pkg::HistIdxW'(1);

    rsp_o.check_done = req_i.chk_en & last;
    rsp_o.matched    = req_i.chk_en & last & ~mis_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < kerh_pkg::HISTORY_DEPTH; i++) begin
        ring_q[i] <= '0;
      end
      idx_q <= '0;
    end else if (req_i.clr) begin
      for (int i = 0; i < kerh_pkg::HISTORY_DEPTH; i++) begin
        ring_q[i] <= '0;
      end
    end else if (req_i.wr_en) begin
      ring_q[idx_q] <= req_i.wr_data;
      idx_q         <= idx_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      mis_q <= 1'b0;
    end else if (req_i.chk_en) begin
      if (last) begin
        pos_q <= '0;
        mis_q <= 1'b0;
      end else begin
        pos_q <= pos_q + kerh_pkg::SeqPosW'(1);
        mis_q <= mis_d;
      end
    end
  end

endmodule

[design/keypad_edge_repeat_history_top.sv]
// keypad edge detect with auto repeat and pressed-key history, top level
// depends on kerh_pkg, kerh_history and keypad_edge_repeat_history_top_defines.svh
//
//   channel | signals                                   | direction
//   in      | in_valid_i / in_ready_o, kind..seq_length | word in
//   out     | out_valid_o / out_ready_i, pressed..match | word out
//   cfg     | cfg_we_i, cfg_index_i, cfg_wdata_i        | register write
//
// one word per cycle sustained while out_ready_i is high; a word goes through the
// input register, then the edge/repeat logic or one ring compare, into the result
// register. reset clears the valid flags, configuration, frame state and history,
// ring included, with no sweep. when the result register is full and not taken,
// ready drops once the input register is also full; nothing is lost or repeated.
`timescale 1ns / 1ps
`include "keypad_edge_repeat_history_top_defines.svh"

module keypad_edge_repeat_history_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [kerh_pkg::KindW-1:0]       kind_i,
  input  logic [kerh_pkg::KEY_WIDTH-1:0]   raw_keys_i,
  input  logic [kerh_pkg::KEY_WIDTH-1:0]   seq_value_i,
  input  logic [kerh_pkg::SeqLenW-1:0]     seq_length_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [kerh_pkg::KEY_WIDTH-1:0]   pressed_keys_o,
  output logic [kerh_pkg::KEY_WIDTH-1:0]   released_keys_o,
  output logic [kerh_pkg::KEY_WIDTH-1:0]   held_keys_out_o,
  output logic [kerh_pkg::KEY_WIDTH-1:0]   repeated_keys_o,
  output logic                             check_done_o,
  output logic                             matched_o,
  input  logic                             cfg_we_i,
  input  logic [kerh_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [kerh_pkg::CfgDataW-1:0]    cfg_wdata_i
);

  // configuration
  logic [kerh_pkg::IntervalW-1:0] interval_q;
  logic [kerh_pkg::KEY_WIDTH-1:0] mask_q;

  // input register
  logic                           s1_valid_q;
  logic [kerh_pkg::KindW-1:0]     s1_kind_q;
  logic [kerh_pkg::KEY_WIDTH-1:0] s1_raw_q;
  logic [kerh_pkg::KEY_WIDTH-1:0] s1_seqv_q;
  logic [kerh_pkg::SeqLenW-1:0]   s1_len_q;

  // frame state; the counter never exceeds the interval so 8 bits suffice
  logic [kerh_pkg::KEY_WIDTH-1:0] held_q,  held_d;
  logic [kerh_pkg::IntervalW-1:0] cnt_q,   cnt_d;
  logic [kerh_pkg::KEY_WIDTH-1:0] rset_q,  rset_d;

  // result register
  logic                           out_valid_q;
  logic [kerh_pkg::KEY_WIDTH-1:0] pressed_q,  pressed_d;
  logic [kerh_pkg::KEY_WIDTH-1:0] released_q, released_d;
  logic [kerh_pkg::KEY_WIDTH-1:0] heldo_q,    heldo_d;
  logic [kerh_pkg::KEY_WIDTH-1:0] repeated_q, repeated_d;
  logic                           done_q,     done_d;
  logic                           match_q,    match_d;

  logic                           out_adv;
  logic                           s1_fire;
  logic [kerh_pkg::KEY_WIDTH-1:0] now;
  logic [kerh_pkg::KEY_WIDTH-1:0] diff;
  logic [kerh_pkg::IntervalW:0]   cnt_next;
  logic                           rep_fire;
  logic [kerh_pkg::KEY_WIDTH-1:0] frame_pressed;
  logic                           frame_upd;

  kerh_pkg::hist_req_t hist_req;
  kerh_pkg::hist_rsp_t hist_rsp;

  assign out_adv    = ~out_valid_q | out_ready_i;
  assign s1_fire    = s1_valid_q & out_adv;
  assign in_ready_o = ~s1_valid_q | out_adv;

  always_comb begin
    now      = ~s1_raw_q;
    diff     = now ^ held_q;
    cnt_next = {1'b0, cnt_q} + (kerh_pkg::IntervalW + 1)'(1);
    rep_fire = cnt_next > {1'b0, interval_q};

    frame_pressed = now & diff;
    if (diff != '0) begin
      rset_d = '0;
      cnt_d  = '0;
    end else if (rep_fire) begin
      // counter parks here, masked keys re-fire every frame
      frame_pressed = frame_pressed | (mask_q & now);
      rset_d        = now;
      cnt_d         = cnt_q;
    end else begin
      rset_d = rset_q;
      cnt_d  = cnt_next[kerh_pkg::IntervalW-1:0];
    end

    frame_upd           = 1'b0;
    held_d              = held_q;
    hist_req.wr_en      = 1'b0;
    hist_req.wr_data    = frame_pressed;
    hist_req.clr        = 1'b0;
    hist_req.chk_en     = 1'b0;
    hist_req.seq_value  = s1_seqv_q;
    hist_req.seq_length = s1_len_q;

    case (s1_kind_q)
      kerh_pkg::KindFrame: begin
        frame_upd      = s1_fire;
        held_d         = now;
        hist_req.wr_en = s1_fire & (frame_pressed != '0);
      end
      kerh_pkg::KindSeq: begin
        hist_req.chk_en = s1_fire;
      end
      kerh_pkg::KindClear: begin
        hist_req.clr = s1_fire;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (s1_kind_q == kerh_pkg::KindFrame) begin
      pressed_d  = frame_pressed;
      released_d = held_q & diff;
      heldo_d    = now;
      repeated_d = rset_d;
      done_d     = 1'b0;
      match_d    = 1'b0;
    end else begin
      pressed_d  = '0;
      released_d = '0;
      heldo_d    = held_q;
      repeated_d = '0;
      done_d     = hist_rsp.check_done;
      match_d    = hist_rsp.matched;
    end
  end

  kerh_history u_history (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (hist_req),
    .rsp_o  (hist_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= '0;
      mask_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        kerh_pkg::RegRepeatInterval: interval_q <= cfg_wdata_i[kerh_pkg::IntervalW-1:0];
        kerh_pkg::RegRepeatMask:     mask_q     <= cfg_wdata_i[kerh_pkg::KEY_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_kind_q <= kind_i;
      s1_raw_q  <= raw_keys_i;
      s1_seqv_q <= seq_value_i;
      s1_len_q  <= seq_length_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      cnt_q  <= '0;
      rset_q <= '0;
    end else if (frame_upd) begin
      held_q <= held_d;
      cnt_q  <= cnt_d;
      rset_q <= rset_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      pressed_q  <= pressed_d;
      released_q <= released_d;
      heldo_q    <= heldo_d;
      repeated_q <= repeated_d;
      done_q     <= done_d;
      match_q    <= match_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pressed_keys_o  = pressed_q;
  assign released_keys_o = released_q;
  assign held_keys_out_o = heldo_q;
  assign repeated_keys_o = repeated_q;
  assign check_done_o    = done_q;
  assign matched_o       = match_q;

  `KERH_ASSERT_IMPLY(a_match_needs_done, out_valid_o && matched_o, check_done_o)
  `KERH_ASSERT_IMPLY(a_done_no_frame_edges, out_valid_o && check_done_o, pressed_keys_o == '0 && released_keys_o == '0 && repeated_keys_o == '0)
  `KERH_ASSERT_IMPLY(a_repeat_is_held_set, out_valid_o && repeated_keys_o != '0, repeated_keys_o == held_keys_out_o)
  `KERH_ASSERT(a_ready_when_empty, (s1_valid_q || out_valid_o) || in_ready_o)

endmodule

[bench/keypad_checker.sv]
// prediction and comparison of result words for the keypad edge, repeat and history block
// depends on kerh_pkg; watches the input, output and register ports of the block
`timescale 1ns / 1ps

module keypad_checker
  import kerh_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [KindW-1:0]     kind_i,
  input  logic [KEY_WIDTH-1:0] raw_keys_i,
  input  logic [KEY_WIDTH-1:0] seq_value_i,
  input  logic [SeqLenW-1:0]   seq_length_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [KEY_WIDTH-1:0] pressed_keys_i,
  input  logic [KEY_WIDTH-1:0] released_keys_i,
  input  logic [KEY_WIDTH-1:0] held_keys_i,
  input  logic [KEY_WIDTH-1:0] repeated_keys_i,
  input  logic                 check_done_i,
  input  logic                 matched_i,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i,
  output int                   errors_o,
  output int                   pending_o
);

  typedef struct packed {
    logic [KEY_WIDTH-1:0] pressed;
    logic [KEY_WIDTH-1:0] released;
    logic [KEY_WIDTH-1:0] held;
    logic [KEY_WIDTH-1:0] repeated;
    logic                 done;
    logic                 matched;
  } keypad_word_t;

  // register copies
  logic [IntervalW-1:0] interval_q;
  logic [KEY_WIDTH-1:0] mask_q;

  // predicted block state
  logic [KEY_WIDTH-1:0] held_q;
  logic [8:0]           rpt_cnt;
  logic [KEY_WIDTH-1:0] rpt_set;
  logic [KEY_WIDTH-1:0] pressed_log [HISTORY_DEPTH];
  logic [HistIdxW-1:0]  log_ptr;
  logic [SeqPosW-1:0]   chk_pos;
  logic                 chk_bad;

  keypad_word_t expected_words [$];
  keypad_word_t got, want;
  int           mismatches = 0;

  function automatic keypad_word_t predict_word(input logic [KindW-1:0] kind,
                                                input logic [KEY_WIDTH-1:0] raw,
                                                input logic [KEY_WIDTH-1:0] seqv,
                                                input logic [SeqLenW-1:0] len);
    keypad_word_t         w;
    logic [KEY_WIDTH-1:0] now, diff;
    logic [9:0]           next_cnt;
    logic [SeqLenW-1:0]   eff_len;
    logic [HistIdxW-1:0]  back;
    w = '0;
    case (kind)
      KindFrame: begin
        now = ~raw;
        diff = now ^ held_q;
        w.pressed = now & diff;
        w.released = held_q & diff;
        if (diff != '0) begin
          rpt_cnt = '0;
          rpt_set = '0;
        end else begin
          next_cnt = {1'b0, rpt_cnt} + 10'd1;
          // counter freezes once past the interval, repeat stays active
          if (next_cnt > {2'b00, interval_q}) begin
            w.pressed |= mask_q & now;
            rpt_set = now;
          end else begin
            rpt_cnt = next_cnt[8:0];
          end
        end
        held_q = now;
        w.repeated = rpt_set;
        if (w.pressed != '0) begin
          pressed_log[log_ptr] = w.pressed;
          log_ptr = log_ptr + 1'b1;
        end
      end
      KindSeq: begin
        eff_len = (len > MaxSeqLen) ? MaxSeqLen : len;
        if (eff_len > {1'b0, chk_pos}) begin
          // distance back from the write pointer, modulo the ring depth
          back = eff_len[HistIdxW-1:0] - chk_pos;
          if (pressed_log[log_ptr - back] != seqv) chk_bad = 1'b1;
        end
        if (eff_len >= MaxSeqLen) chk_bad = 1'b1;
        if ({1'b0, chk_pos} + 5'd1 >= eff_len) begin
          w.done = 1'b1;
          w.matched = !chk_bad;
          chk_pos = '0;
          chk_bad = 1'b0;
        end else begin
          chk_pos = chk_pos + 1'b1;
        end
      end
      KindClear: begin
        for (int i = 0; i < HISTORY_DEPTH; i++) pressed_log[i] = '0;
      end
      default: begin
      end
    endcase
    w.held = held_q;
    return w;
  endfunction

  function automatic string word_text(input keypad_word_t w);
    return $sformatf("pressed %h released %h held %h repeated %h done %0d matched %0d",
                     w.pressed, w.released, w.held, w.repeated, w.done, w.matched);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q = '0;
      mask_q = '0;
      held_q = '0;
      rpt_cnt = '0;
      rpt_set = '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) pressed_log[i] = '0;
      log_ptr = '0;
      chk_pos = '0;
      chk_bad = 1'b0;
      expected_words.delete();
      pending_o <= 0;
      errors_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = '{pressed_keys_i, released_keys_i, held_keys_i, repeated_keys_i,
                check_done_i, matched_i};
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word: %s", word_text(got));
        end else begin
          want = expected_words.pop_front();
          if (got.pressed !== want.pressed || got.released !== want.released ||
              got.held !== want.held || got.repeated !== want.repeated ||
              got.done !== want.done || got.matched !== want.matched) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch at %0t", $realtime);
              $display("  expected %s", word_text(want));
              $display("  actual   %s", word_text(got));
            end
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegRepeatInterval: interval_q = cfg_wdata_i[IntervalW-1:0];
          RegRepeatMask:     mask_q = cfg_wdata_i[KEY_WIDTH-1:0];
          default: begin
          end
        endcase
      end
      if (in_valid_i && in_ready_i)
        expected_words.push_back(predict_word(kind_i, raw_keys_i, seq_value_i, seq_length_i));
      pending_o <= expected_words.size();
      errors_o <= mismatches;
    end
  end

endmodule

[bench/tb_top.sv]
// top of the keypad edge, repeat and history bench: clock, reset, stimulus and verdict
// depends on kerh_pkg, keypad_edge_repeat_history_top and keypad_checker
`timescale 1ns / 1ps

module tb_top;
  import kerh_pkg::*;

  localparam logic [KindW-1:0] KindUnused = 2'd3;
  localparam int HoldCycles  = 300;
  localparam int StallLimit  = 3000;
  localparam int PhaseWords  = 100;
  localparam int DrainCycles = 8;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [KindW-1:0]     kind_i = KindFrame;
  logic [KEY_WIDTH-1:0] raw_keys_i = '1;
  logic [KEY_WIDTH-1:0] seq_value_i = '0;
  logic [SeqLenW-1:0]   seq_length_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [KEY_WIDTH-1:0] pressed_keys_o, released_keys_o, held_keys_out_o, repeated_keys_o;
  logic                 check_done_o, matched_o;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_wdata_i = '0;

  int                   errors, pending;
  int unsigned          words_sent = 0;
  int unsigned          hold_requests = 0;
  int unsigned          holds_served = 0;
  bit                   steady = 1'b0;
  bit                   check_dirty = 1'b0;
  logic [IntervalW-1:0] cur_interval = '0;
  logic [KEY_WIDTH-1:0] last_raw = '1;

  initial forever #10 clk_i = ~clk_i;

  keypad_edge_repeat_history_top dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .kind_i, .raw_keys_i, .seq_value_i, .seq_length_i,
    .out_valid_o, .out_ready_i, .pressed_keys_o, .released_keys_o, .held_keys_out_o,
    .repeated_keys_o, .check_done_o, .matched_o,
    .cfg_we_i, .cfg_index_i, .cfg_wdata_i
  );

  keypad_checker u_keypad_chk (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .kind_i, .raw_keys_i, .seq_value_i, .seq_length_i,
    .out_valid_i(out_valid_o), .out_ready_i, .pressed_keys_i(pressed_keys_o),
    .released_keys_i(released_keys_o), .held_keys_i(held_keys_out_o),
    .repeated_keys_i(repeated_keys_o), .check_done_i(check_done_o), .matched_i(matched_o),
    .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .errors_o(errors), .pending_o(pending)
  );

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [KEY_WIDTH-1:0] rand_keys();
    if ($urandom_range(0, 9) < 3) return KEY_WIDTH'(1) << $urandom_range(0, KEY_WIDTH - 1);
    return KEY_WIDTH'($urandom_range(1, 2**KEY_WIDTH - 1));
  endfunction

  task automatic send_word(input logic [KindW-1:0] kind, input logic [KEY_WIDTH-1:0] raw,
                           input logic [KEY_WIDTH-1:0] seqv, input logic [SeqLenW-1:0] len);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    raw_keys_i <= raw;
    seq_value_i <= seqv;
    seq_length_i <= len;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic key_run(input logic [KEY_WIDTH-1:0] raw, input int frames);
    for (int i = 0; i < frames; i++)
      send_word(KindFrame, raw, KEY_WIDTH'($urandom), SeqLenW'($urandom));
    last_raw = raw;
  endtask

  // release-press pairs put exactly the chosen key sets into the history, then the code
  // is streamed back, optionally with one element spoiled
  task automatic enter_code(input int len, input bit spoil);
    logic [KEY_WIDTH-1:0] keys [16];
    int                   bad_pos;
    if (check_dirty) begin
      send_word(KindSeq, KEY_WIDTH'($urandom), KEY_WIDTH'($urandom), '0);
      check_dirty = 1'b0;
    end
    for (int j = 0; j < len; j++) begin
      keys[j] = rand_keys();
      send_word(KindFrame, '1, KEY_WIDTH'($urandom), SeqLenW'($urandom));
      send_word(KindFrame, ~keys[j], KEY_WIDTH'($urandom), SeqLenW'($urandom));
    end
    last_raw = ~keys[len-1];
    bad_pos = spoil ? $urandom_range(0, len - 1) : -1;
    for (int j = 0; j < len; j++) begin
      // an all-released frame mid-check leaves the history alone
      if ($urandom_range(0, 9) == 0) begin
        send_word(KindFrame, '1, KEY_WIDTH'($urandom), SeqLenW'($urandom));
        last_raw = '1;
      end
      send_word(KindSeq, KEY_WIDTH'($urandom), (j == bad_pos) ? keys[j] ^ rand_keys() : keys[j],
                SeqLenW'(len));
    end
  endtask

  task automatic random_phase(input int n_words);
    int unsigned          stop;
    int                   r;
    logic [KEY_WIDTH-1:0] raw;
    stop = words_sent + n_words;
    while (words_sent < stop) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        enter_code(($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(5, 15),
                   r < 12);
      end else if (r < 70) begin
        case ($urandom_range(0, 3))
          0:       raw = last_raw ^ (KEY_WIDTH'(1) << $urandom_range(0, KEY_WIDTH - 1));
          1:       raw = '1;
          2:       raw = '0;
          default: raw = KEY_WIDTH'($urandom);
        endcase
        key_run(raw, (cur_interval <= 8) ? $urandom_range(1, cur_interval + 4)
                                         : $urandom_range(1, 6));
      end else if (r < 75) begin
        send_word(KindClear, KEY_WIDTH'($urandom), KEY_WIDTH'($urandom), SeqLenW'($urandom));
      end else begin
        repeat ($urandom_range(1, 4))
          send_word(KindW'($urandom_range(0, 2**KindW - 1)), KEY_WIDTH'($urandom),
                    KEY_WIDTH'($urandom), SeqLenW'($urandom));
        check_dirty = 1'b1;
      end
    end
  endtask

  // receiver: random stalls, plus a long hold-off when asked for
  initial begin : receiver
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (holds_served != hold_requests) begin
        holds_served++;
        out_ready_i <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk_i);
      end else if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_reg(RegRepeatInterval, '0);
    cur_interval = '0;
    write_reg(RegRepeatMask, '1);

    // nothing held, all keys at once, then held so every key repeats
    send_word(KindFrame, 16'hFFFF, '0, '0);
    send_word(KindFrame, 16'h0000, '0, '0);
    send_word(KindFrame, 16'h0000, '0, '0);
    send_word(KindFrame, 16'hAAAA, '0, '0);
    send_word(KindFrame, 16'h5555, '0, '0);
    // two-word code whose first element misses, then an empty one
    send_word(KindSeq, '0, 16'h5555, 5'd2);
    send_word(KindSeq, '0, 16'hAAAA, 5'd2);
    send_word(KindSeq, '1, '1, 5'd0);
    // over-long length, then the length shrinks under the open check
    send_word(KindSeq, '0, 16'h0000, 5'd31);
    send_word(KindSeq, '0, 16'hAAAA, 5'd1);
    send_word(KindUnused, '0, '1, 5'd31);
    // length sixteen with a frame in between, closed by an empty element
    send_word(KindSeq, '0, 16'hFFFF, 5'd16);
    send_word(KindFrame, 16'hFFFF, '1, 5'd16);
    send_word(KindSeq, '0, '0, 5'd0);
    // cleared history matches zeros, also with a clear inside the check
    send_word(KindClear, '1, '1, '1);
    send_word(KindSeq, '0, 16'h0000, 5'd1);
    send_word(KindSeq, '0, 16'h0000, 5'd3);
    send_word(KindClear, '0, '0, '0);
    send_word(KindSeq, '0, 16'h0000, 5'd3);
    send_word(KindSeq, '0, 16'h0000, 5'd3);
    send_word(KindFrame, 16'h7FFE, '0, '0);
    random_phase(PhaseWords);
    drain();

    // slowest repeat: only a very long unchanged run gets past the interval
    write_reg(RegRepeatInterval, {8'($urandom), 8'hFF});
    cur_interval = 8'hFF;
    write_reg(RegRepeatMask, CfgDataW'($urandom));
    key_run(rand_keys() ^ KEY_WIDTH'($urandom), 260);
    random_phase(PhaseWords);
    drain();

    // receiver holds off while the sender keeps offering words
    write_reg(RegRepeatInterval, CfgDataW'(3));
    cur_interval = 8'd3;
    write_reg(RegRepeatMask, CfgDataW'($urandom));
    steady = 1'b1;
    hold_requests++;
    random_phase(PhaseWords);
    steady = 1'b0;
    drain();

    // no idling on either side
    write_reg(RegRepeatInterval, '0);
    cur_interval = '0;
    write_reg(RegRepeatMask, '0);
    steady = 1'b1;
    random_phase(PhaseWords);
    steady = 1'b0;
    drain();

    write_reg(RegRepeatInterval, CfgDataW'($urandom_range(0, 255)));
    write_reg(RegRepeatMask, '1);
    cur_interval = 8'hFF;
    random_phase(PhaseWords);
    drain();

    write_reg(RegRepeatInterval, CfgDataW'(1));
    cur_interval = 8'd1;
    write_reg(RegRepeatMask, CfgDataW'($urandom));
    random_phase(PhaseWords);
    drain();

    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
